// File: sv/spq_pkg.sv
package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int VALUE_W = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int STAT_W  = 2;

    typedef logic signed [VALUE_W-1:0] t_val;
    typedef logic [CNT_W-1:0]          t_cnt;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // control broadcast to every cell
    typedef struct packed {
        logic load;
        t_op  op;
    } t_cell_ctl;

    // signals rippling from a cell to the next one towards the tail
    typedef struct packed {
        logic ins;
        logic hit;
    } t_link;

endpackage

// File: sv/spq_cell.sv
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occ,
    input  spq_pkg::t_val      i_value,
    input  spq_pkg::t_link     i_link,
    input  spq_pkg::t_val      i_left_value,
    input  spq_pkg::t_val      i_right_value,
    output spq_pkg::t_link     o_link,
    output spq_pkg::t_val      o_value,
    output spq_pkg::t_val      o_next
);
    import spq_pkg::*;

    t_val r_value;
    t_val n_value;

    // empty cells behave as minus infinity, so the insert flag stays monotonic
    assign o_link.ins = !i_occ || (r_value <= i_value);
    assign o_link.hit = i_link.hit || (i_occ && (r_value == i_value));

    always_comb begin
        n_value = r_value;
        if (i_ctl.op == OP_INSERT) begin
            if (o_link.ins) begin
                n_value = i_link.ins ? i_left_value : i_value;
            end
        end else begin
            if (o_link.hit) begin
                n_value = i_right_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;
    assign o_next  = i_ctl.load ? n_value : r_value;

endmodule

// File: sv/sorted_priority_queue_core.sv
// Channel  | Valid        | Stall        | Payload
// ---------+--------------+--------------+------------------------------------------
// request  | i_in_valid   | o_in_stall   | i_op, i_value
// result   | o_out_valid  | i_out_stall  | o_status, o_count, o_head_valid, o_head_value
//
// Every request is finished in the cycle it is accepted: all cells compare and shift
// together, and the result is registered as the cells load. A new request can follow
// every cycle while the result register is free or being taken.
// Reset (synchronous, active low) clears the count and the result valid; the
// entries themselves are not cleared. A stalled result holds the request side off.
module sorted_priority_queue_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_op,
    input  logic signed [spq_pkg::VALUE_W-1:0] i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [spq_pkg::STAT_W-1:0]  o_status,
    output logic [spq_pkg::CNT_W-1:0]   o_count,
    output logic                        o_head_valid,
    output logic signed [spq_pkg::VALUE_W-1:0] o_head_value
);
    import spq_pkg::*;

    t_cnt      r_count;
    logic      r_out_valid;
    t_status   r_status;
    t_cnt      r_out_count;
    t_val      r_head;

    t_cnt      n_count;
    t_status   n_status;
    t_val      n_head;

    logic      accept;
    logic      full;
    t_op       op;
    t_cell_ctl ctl;

    t_link     link [DEPTH+1];
    t_val      cell_value [DEPTH];
    t_val      cell_next [DEPTH];
    logic      occ [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign op         = t_op'(i_op);
    assign full       = (r_count == t_cnt'(DEPTH));

    assign ctl.op   = op;
    assign ctl.load = accept && ((op == OP_DELETE) || !full);

    assign link[0].ins = 1'b0;
    assign link[0].hit = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign occ[g] = (t_cnt'(g) < r_count);

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_occ         (occ[g]),
            .i_value       (i_value),
            .i_link        (link[g]),
            .i_left_value  ((g == 0) ? i_value : cell_value[(g == 0) ? 0 : g - 1]),
            .i_right_value (cell_value[(g == DEPTH - 1) ? g : g + 1]),
            .o_link        (link[g+1]),
            .o_value       (cell_value[g]),
            .o_next        (cell_next[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        if (op == OP_INSERT) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + t_cnt'(1);
            end
        end else begin
            if (link[DEPTH].hit) begin
                n_count = r_count - t_cnt'(1);
            end else begin
                n_status = ST_NOT_FOUND;
            end
        end
        n_head = (n_count != '0) ? cell_next[0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_status    <= n_status;
            r_out_count <= n_count;
            r_head      <= n_head;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_count      = r_out_count;
    assign o_head_valid = (r_out_count != '0);
    assign o_head_value = r_head;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(DEPTH))
        else $error("entry count beyond depth");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && op == OP_INSERT && full) |=> (r_status == ST_FULL && $stable(r_count)))
        else $error("insert on a full store was not refused");

    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_count))
        else $error("count changed without a request");

    a_result_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_out_valid && r_out_count == r_count))
        else $error("result count does not match store");

endmodule
